@@ rtl/rsl_pkg.sv @@
// ----------------------------------------------------------------------------
// rsl_pkg: shared types and constants for the rtp sequence loss tracker
// state encoding, controller commands and status, wrap thresholds
// ----------------------------------------------------------------------------
package rsl_pkg;

  localparam int unsigned SeqW   = 16;
  localparam int unsigned CountW = 33;
  localparam int unsigned FracW  = 8;

  // wrap detection thresholds
  localparam logic [SeqW-1:0]   WrapHighSeq = 16'hFF00;
  localparam logic [SeqW-1:0]   WrapLowSeq  = 16'h00FF;
  localparam logic [CountW-1:0] WrapSpacing = 33'h0_0000_1FFF;

  localparam logic [SeqW-1:0]   WrapMax  = 16'hFFFF;
  localparam logic [CountW-1:0] CountMax = 33'h1_FFFF_FFFF;
  localparam logic [FracW-1:0]  FracMax  = 8'hFF;

  // one quotient bit per step
  localparam int unsigned DivSteps = FracW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // function codes of an input word
  localparam logic FuncPacket = 1'b0;
  localparam logic FuncReport = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_EXPECT,
    S_LOST,
    S_INTERVAL,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic calc_expected;
    logic calc_lost;
    logic calc_interval;
    logic calc_check;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_report;
    logic out_free;
  } ctrl_status_t;

endpackage

@@ rtl/rsl_req_if.sv @@
// ----------------------------------------------------------------------------
// rsl_req_if: request channel
// valid/ready handshake carrying the function code and sequence number
// ----------------------------------------------------------------------------
interface rsl_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [rsl_pkg::SeqW-1:0]  seq;

  modport source (output valid, output func, output seq, input ready);
  modport sink   (input valid, input func, input seq, output ready);
endinterface

@@ rtl/rsl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rsl_rsp_if: result channel
// valid/ready handshake carrying the loss statistics of one word
// ----------------------------------------------------------------------------
interface rsl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rsl_pkg::CountW-1:0]  lost_total;
  logic [rsl_pkg::FracW-1:0]   loss_fraction;
  logic [rsl_pkg::CountW-1:0]  expected_total;

  modport source (output valid, output lost_total, output loss_fraction,
                  output expected_total, input ready);
  modport sink   (input valid, input lost_total, input loss_fraction,
                  input expected_total, output ready);
endinterface

@@ rtl/rtp_sequence_loss_tracker.sv @@
// ----------------------------------------------------------------------------
// rtp_sequence_loss_tracker: rtp receive sequence and loss statistics
// counts sequence wraps and packets, reports cumulative and interval loss
// ----------------------------------------------------------------------------
// flow: a packet word steps through update, expected, lost and done; a report
//   word also steps through interval, check and the bit-serial divider
// throughput: one word at a time; the next word is accepted in the cycle after
//   the result is loaded, even while that result still waits on rsp.ready
// reset: synchronous rst clears all counters, sequence state and valid flags
// ----------------------------------------------------------------------------
module rtp_sequence_loss_tracker (
  input  logic        clk,
  input  logic        rst,
  rsl_req_if.sink     req,
  rsl_rsp_if.source   rsp
);

  // command and status bundles between controller and datapath
  rsl_pkg::ctrl_cmd_t    cmd;
  rsl_pkg::ctrl_status_t status;

  // controller: sequences update, totals, interval check and division
  rsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: tracker state, arithmetic and the output register
  rsl_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .in_func            (req.func),
    .in_seq             (req.seq),
    .out_valid          (rsp.valid),
    .out_ready          (rsp.ready),
    .out_lost_total     (rsp.lost_total),
    .out_loss_fraction  (rsp.loss_fraction),
    .out_expected_total (rsp.expected_total)
  );

  // lost count is clamped, so it never exceeds the expected count
  a_lost_le_expected: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.lost_total <= rsp.expected_total))
    else $error("lost total above expected total");

  // one word in flight: no acceptance right after an acceptance
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second word accepted while busy");

  // a loaded result always shows up on the result port
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp.valid)
    else $error("loaded result not presented");

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result loaded over a pending word");

endmodule

@@ rtl/rsl_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsl_ctrl: sequencing controller
// walks one word through update and totals, a report also through interval and serial division
// ----------------------------------------------------------------------------
module rsl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rsl_pkg::ctrl_status_t status,
  output rsl_pkg::ctrl_cmd_t    cmd
);

  rsl_pkg::state_t              state;
  rsl_pkg::state_t              state_next;
  logic [rsl_pkg::DivCntW-1:0]  div_cnt;
  logic [rsl_pkg::DivCntW-1:0]  div_cnt_next;

  localparam logic [rsl_pkg::DivCntW-1:0] DivLast =
    rsl_pkg::DivCntW'(rsl_pkg::DivSteps - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rsl_pkg::S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      rsl_pkg::S_IDLE: begin
        // no word is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = rsl_pkg::S_UPDATE;
        end
      end
      rsl_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = rsl_pkg::S_EXPECT;
      end
      rsl_pkg::S_EXPECT: begin
        cmd.calc_expected = 1'b1;
        state_next        = rsl_pkg::S_LOST;
      end
      rsl_pkg::S_LOST: begin
        cmd.calc_lost = 1'b1;
        state_next    = status.is_report ? rsl_pkg::S_INTERVAL : rsl_pkg::S_DONE;
      end
      rsl_pkg::S_INTERVAL: begin
        cmd.calc_interval = 1'b1;
        state_next        = rsl_pkg::S_CHECK;
      end
      rsl_pkg::S_CHECK: begin
        cmd.calc_check = 1'b1;
        div_cnt_next   = '0;
        state_next     = rsl_pkg::S_DIV;
      end
      rsl_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DivLast) begin
          state_next = rsl_pkg::S_DONE;
        end
      end
      rsl_pkg::S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = rsl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rsl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/rsl_datapath.sv @@
// ----------------------------------------------------------------------------
// rsl_datapath: sequence state, totals, interval and restoring divider
// holds the tracker state and the output register
// ----------------------------------------------------------------------------
module rsl_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  rsl_pkg::ctrl_cmd_t           cmd,
  output rsl_pkg::ctrl_status_t        status,
  input  logic                         in_func,
  input  logic [rsl_pkg::SeqW-1:0]     in_seq,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rsl_pkg::CountW-1:0]   out_lost_total,
  output logic [rsl_pkg::FracW-1:0]    out_loss_fraction,
  output logic [rsl_pkg::CountW-1:0]   out_expected_total
);

  localparam int unsigned SW = rsl_pkg::SeqW;
  localparam int unsigned CW = rsl_pkg::CountW;
  localparam int unsigned FW = rsl_pkg::FracW;

  // captured word
  logic          func;
  logic [SW-1:0] seq;

  // tracker state
  logic [SW-1:0] wrap_count;
  logic [SW-1:0] highest_seq;
  logic [SW-1:0] start_seq;
  logic [SW-1:0] previous_seq;
  logic [CW-1:0] received_count;
  logic [CW-1:0] count_at_wrap;
  logic [CW-1:0] lost_at_report;
  logic [CW-1:0] expected_at_report;

  // working registers
  logic [CW-1:0] expected;
  logic [CW-1:0] lost;
  logic [CW:0]   exp_diff;
  logic [CW-1:0] divisor;
  logic [CW:0]   rem;
  logic [FW-1:0] quot;
  logic          frac_zero;
  logic          frac_sat;

  // packet update
  logic          wrap_hit;
  logic [SW-1:0] wrap_count_next;
  logic [CW:0]   exp_sum;
  logic          exp_pos;
  logic          lost_ge;
  logic [CW:0]   rem_sh;
  logic          rem_ge;

  assign wrap_hit = (previous_seq > rsl_pkg::WrapHighSeq) && (seq < rsl_pkg::WrapLowSeq) &&
                    ((wrap_count == '0) ||
                     ((received_count - count_at_wrap) > rsl_pkg::WrapSpacing));

  assign wrap_count_next = (wrap_hit && (wrap_count != rsl_pkg::WrapMax)) ?
                           wrap_count + 1'b1 : wrap_count;

  // signed extended span, top bit set means negative
  assign exp_sum = {2'b00, wrap_count, {SW{1'b0}}} + (CW+1)'(highest_seq)
                   - (CW+1)'(start_seq) + (CW+1)'(1);

  assign exp_pos = !exp_diff[CW] && (exp_diff != '0);
  assign lost_ge = lost >= lost_at_report;

  assign rem_sh = {rem[CW-1:0], 1'b0};
  assign rem_ge = rem_sh >= {1'b0, divisor};

  assign status.is_report = (func == rsl_pkg::FuncReport);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func <= in_func;
      seq  <= in_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_count         <= '0;
      highest_seq        <= '0;
      start_seq          <= '0;
      previous_seq       <= '0;
      received_count     <= '0;
      count_at_wrap      <= '0;
      lost_at_report     <= '0;
      expected_at_report <= '0;
    end else begin
      if (cmd.update && (func == rsl_pkg::FuncPacket)) begin
        wrap_count <= wrap_count_next;
        if (wrap_hit) begin
          count_at_wrap <= received_count;
          highest_seq   <= seq;
        end else if (seq > highest_seq) begin
          highest_seq <= seq;
        end
        if (received_count == '0) begin
          start_seq <= seq;
        end else if ((wrap_count_next == '0) && (seq < start_seq)) begin
          start_seq <= seq;
        end
        previous_seq <= seq;
        if (received_count != rsl_pkg::CountMax) begin
          received_count <= received_count + 1'b1;
        end
      end
      if (cmd.calc_lost && (func == rsl_pkg::FuncReport)) begin
        expected_at_report <= expected;
      end
      if (cmd.calc_interval && exp_pos && lost_ge) begin
        lost_at_report <= lost;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_expected) begin
      expected <= exp_sum[CW] ? '0 : exp_sum[CW-1:0];
    end
    if (cmd.calc_lost) begin
      lost     <= (expected > received_count) ? expected - received_count : '0;
      exp_diff <= {1'b0, expected} - {1'b0, expected_at_report};
    end
    if (cmd.calc_interval) begin
      frac_zero <= !exp_pos;
      divisor   <= exp_diff[CW-1:0];
      rem       <= lost_ge ? {1'b0, lost - lost_at_report} : '0;
      quot      <= '0;
    end
    if (cmd.calc_check) begin
      frac_sat <= rem[CW-1:0] >= divisor;
    end
    if (cmd.div_step) begin
      rem  <= rem_ge ? rem_sh - {1'b0, divisor} : rem_sh;
      quot <= {quot[FW-2:0], rem_ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_lost_total     <= lost;
      out_expected_total <= expected;
      if ((func == rsl_pkg::FuncPacket) || frac_zero) begin
        out_loss_fraction <= '0;
      end else if (frac_sat) begin
        out_loss_fraction <= rsl_pkg::FracMax;
      end else begin
        out_loss_fraction <= quot;
      end
    end
  end

endmodule

@@ sim/rtp_sequence_loss_tracker_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_sequence_loss_tracker_test: self-checking bench for the loss tracker
// drives packet and report words through the request channel with bursty
// traffic, stalls the result channel on a rotating pattern, and checks every
// result word against an in-bench loss predictor or a pinned value
// ----------------------------------------------------------------------------
module rtp_sequence_loss_tracker_test;

  localparam int unsigned RandomWords = 1250;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned NumDirected = 21;

  // one result word as the block presents it
  typedef struct packed {
    logic [rsl_pkg::CountW-1:0] lost;
    logic [rsl_pkg::FracW-1:0]  frac;
    logic [rsl_pkg::CountW-1:0] expected;
  } loss_stats_t;

  // one row of the directed table; pinned rows carry a hand-read result
  typedef struct packed {
    logic                     func;
    logic [rsl_pkg::SeqW-1:0] seq;
    logic                     pinned;
    loss_stats_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  rsl_req_if req ();
  rsl_rsp_if rsp ();

  rtp_sequence_loss_tracker dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // loss predictor state, cleared like the block at reset
  // --------------------------------------------------------------------------
  logic [rsl_pkg::SeqW-1:0]   wraps              = '0;
  logic [rsl_pkg::SeqW-1:0]   top_seq            = '0;
  logic [rsl_pkg::SeqW-1:0]   first_seq          = '0;
  logic [rsl_pkg::SeqW-1:0]   last_seq           = '0;
  logic [rsl_pkg::CountW-1:0] pkt_count          = '0;
  logic [rsl_pkg::CountW-1:0] count_at_last_wrap = '0;
  logic [rsl_pkg::CountW-1:0] lost_reported      = '0;
  logic [rsl_pkg::CountW-1:0] expected_reported  = '0;

  loss_stats_t pending_stats[$];
  int          error_count = 0;
  int          word_count  = 0;

  // sender burst shaping
  int                       burst_left = 0;
  bit                       steady     = 1'b0;
  logic [rsl_pkg::SeqW-1:0] cursor     = '0;

  // extended highest minus start plus one, never below zero
  function automatic logic [rsl_pkg::CountW-1:0] expected_span();
    longint span;
    span = (longint'(wraps) << 16) + longint'(top_seq) - longint'(first_seq) + 1;
    return (span > 0) ? span[rsl_pkg::CountW-1:0] : '0;
  endfunction

  // advance the predictor by one accepted word and return its result word
  function automatic loss_stats_t track_word(input logic func,
                                             input logic [rsl_pkg::SeqW-1:0] seq);
    loss_stats_t                stats;
    longint                     interval;
    longint                     quotient;
    logic [rsl_pkg::CountW-1:0] lost_part;
    stats = '0;
    if (func == rsl_pkg::FuncPacket) begin
      // wrap only from near the top to near zero, and only if the first wrap
      // or far enough from the previous one
      if (last_seq > rsl_pkg::WrapHighSeq && seq < rsl_pkg::WrapLowSeq &&
          (wraps == '0 || (pkt_count - count_at_last_wrap) > rsl_pkg::WrapSpacing)) begin
        if (wraps != rsl_pkg::WrapMax) wraps++;
        count_at_last_wrap = pkt_count;
        top_seq = seq;
      end else if (seq > top_seq) begin
        top_seq = seq;
      end
      if (pkt_count == '0) begin
        first_seq = seq;
      end else if (wraps == '0 && seq < first_seq) begin
        first_seq = seq;
      end
      last_seq = seq;
      if (pkt_count != rsl_pkg::CountMax) pkt_count++;
    end
    stats.expected = expected_span();
    stats.lost = (stats.expected > pkt_count) ? stats.expected - pkt_count : '0;
    if (func == rsl_pkg::FuncReport) begin
      interval = longint'(stats.expected) - longint'(expected_reported);
      expected_reported = stats.expected;
      if (interval > 0) begin
        // a shrinking loss count gives an empty lost interval
        lost_part = '0;
        if (stats.lost >= lost_reported) begin
          lost_part = stats.lost - lost_reported;
          lost_reported = stats.lost;
        end
        quotient = (longint'(lost_part) << 8) / interval;
        stats.frac = (quotient > longint'(rsl_pkg::FracMax)) ?
                     rsl_pkg::FracMax : quotient[rsl_pkg::FracW-1:0];
      end
    end
    return stats;
  endfunction

  // --------------------------------------------------------------------------
  // directed table: reset state, start lowering, first wrap, shrinking loss,
  // wrap thresholds at their edges
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [NumDirected] = '{
    // report straight after reset: one expected, none received
    '{rsl_pkg::FuncReport, 16'hFFFF, 1'b1, '{33'd1, 8'd255, 33'd1}},
    '{rsl_pkg::FuncPacket, 16'h1000, 1'b1, '{33'd0, 8'd0, 33'd1}},
    // lower seq before any wrap pulls the start down
    '{rsl_pkg::FuncPacket, 16'h0800, 1'b1, '{33'h7FF, 8'd0, 33'h801}},
    // almost every expected word lost, fraction at its top value
    '{rsl_pkg::FuncReport, 16'hABCD, 1'b1, '{33'h7FF, 8'd255, 33'h801}},
    // empty expected interval
    '{rsl_pkg::FuncReport, 16'h0000, 1'b1, '{33'h7FF, 8'd0, 33'h801}},
    '{rsl_pkg::FuncPacket, 16'h0000, 1'b0, '0},
    '{rsl_pkg::FuncPacket, 16'hFFFF, 1'b1, '{33'hFFFC, 8'd0, 33'h10000}},
    // first wrap
    '{rsl_pkg::FuncPacket, 16'h0000, 1'b1, '{33'hFFFC, 8'd0, 33'h10001}},
    '{rsl_pkg::FuncReport, 16'h5555, 1'b0, '0},
    '{rsl_pkg::FuncPacket, 16'h0001, 1'b0, '0},
    '{rsl_pkg::FuncPacket, 16'h0002, 1'b0, '0},
    '{rsl_pkg::FuncPacket, 16'h0003, 1'b0, '0},
    // duplicate drops the loss count below the reported one
    '{rsl_pkg::FuncPacket, 16'h0001, 1'b0, '0},
    '{rsl_pkg::FuncPacket, 16'h0004, 1'b0, '0},
    '{rsl_pkg::FuncReport, 16'hAAAA, 1'b0, '0},
    '{rsl_pkg::FuncPacket, 16'hFF01, 1'b0, '0},
    // wrap pattern too soon after the first wrap
    '{rsl_pkg::FuncPacket, 16'h00FE, 1'b0, '0},
    // previous seq right at the high threshold
    '{rsl_pkg::FuncPacket, 16'hFF00, 1'b0, '0},
    '{rsl_pkg::FuncPacket, 16'h0000, 1'b0, '0},
    '{rsl_pkg::FuncPacket, 16'h00FF, 1'b0, '0},
    '{rsl_pkg::FuncReport, 16'h0000, 1'b0, '0}
  };

  // offer one word, wait for the handshake, book its result, then maybe idle
  task automatic issue_word(input logic func, input logic [rsl_pkg::SeqW-1:0] seq,
                            input logic pinned, input loss_stats_t want);
    loss_stats_t predicted;
    int          gap;
    req.valid <= 1'b1;
    req.func  <= func;
    req.seq   <= seq;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted = track_word(func, seq);
    pending_stats.push_back(pinned ? want : predicted);
    word_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // new burst; now and then a stretch with no gaps at all
      burst_left = $urandom_range(1, 24);
      steady = ($urandom_range(0, 5) == 0);
      gap = steady ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // in-order traffic from the cursor; lossy streams also skip, repeat,
  // reorder and jump
  task automatic play_stream(input int words, input int report_pct, input bit lossy);
    int                       pick;
    logic [rsl_pkg::SeqW-1:0] seq;
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(0, 99) < report_pct) begin
        issue_word(rsl_pkg::FuncReport, 16'($urandom), 1'b0, '0);
      end else begin
        pick = $urandom_range(0, 99);
        if (!lossy) begin
          // mostly in order, a few duplicates
          if (pick >= 4) cursor++;
          seq = cursor;
        end else if (pick < 65) begin
          cursor++;
          seq = cursor;
        end else if (pick < 77) begin
          cursor = cursor + 16'($urandom_range(2, 6));
          seq = cursor;
        end else if (pick < 85) begin
          seq = cursor;
        end else if (pick < 95) begin
          // late word, cursor stays
          seq = cursor - 16'($urandom_range(1, 8));
        end else begin
          cursor = 16'($urandom);
          seq = cursor;
        end
        issue_word(rsl_pkg::FuncPacket, seq, 1'b0, '0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sender: reset, directed table, random traffic, drain
  // --------------------------------------------------------------------------
  initial begin : sender
    rst       = 1'b1;
    req.valid = 1'b0;
    req.func  = rsl_pkg::FuncPacket;
    req.seq   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NumDirected; r++) begin
      issue_word(directed_rows[r].func, directed_rows[r].seq,
                 directed_rows[r].pinned, directed_rows[r].want);
    end

    // random part: mostly streams with random content, some noise
    while (word_count < NumDirected + RandomWords) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 4))
          0, 1:    cursor = 16'hFF00 + 16'($urandom_range(0, 16'hF0));
          2:       cursor = 16'($urandom);
          default: ;
        endcase
        play_stream($urandom_range(8, 48), 10, 1'b1);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          issue_word(1'($urandom), 16'($urandom), 1'b0, '0);
        end
      end
    end

    req.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: ready follows a rotating pattern, changed every so often
  // --------------------------------------------------------------------------
  initial begin : receiver
    logic [15:0] stall_pattern;
    int          hold;
    rsp.ready = 1'b0;
    stall_pattern = 16'hFFFF;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        hold = $urandom_range(32, 256);
        case ($urandom_range(0, 3))
          0:       stall_pattern = 16'hFFFF;
          1:       stall_pattern = 16'($urandom) | 16'h0001;
          2:       stall_pattern = 16'($urandom & $urandom) | 16'h0001;
          default: stall_pattern = 16'h0001;
        endcase
      end else begin
        hold--;
      end
      rsp.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // --------------------------------------------------------------------------
  // result checking against the oldest booked word
  // --------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [rsl_pkg::CountW-1:0] want,
                             input logic [rsl_pkg::CountW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    loss_stats_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: result word with nothing pending, expected none, actual %0h/%0h/%0h",
                 $time, rsp.lost_total, rsp.loss_fraction, rsp.expected_total);
        error_count++;
      end else begin
        want = pending_stats.pop_front();
        check_field("lost_total", want.lost, rsp.lost_total);
        check_field("loss_fraction", rsl_pkg::CountW'(want.frac),
                    rsl_pkg::CountW'(rsp.loss_fraction));
        check_field("expected_total", want.expected, rsp.expected_total);
      end
    end
  end

  // watchdog: too long with no word moving on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
rtl/rsl_pkg.sv
rtl/rsl_req_if.sv
rtl/rsl_rsp_if.sv
rtl/rsl_ctrl.sv
rtl/rsl_datapath.sv
rtl/rtp_sequence_loss_tracker.sv
sim/rtp_sequence_loss_tracker_test.sv
